// ===== hw/rtl/ple_pkg.sv =====
package ple_pkg;

    localparam int CHAN_W   = 4;
    localparam int SAMPLE_W = 32;
    localparam int STAMP_W  = 48;
    localparam int MAG_W    = 48;
    localparam int CAP_W    = 41;
    localparam int PROD_W   = 2 * MAG_W;
    localparam int STEPS    = 48;
    localparam int CNT_W    = 6;

    localparam logic REQ_UPDATE = 1'b0;
    localparam logic REQ_QUERY  = 1'b1;

    localparam logic [CAP_W-1:0] MAG_CAP = {1'b1, {(CAP_W-1){1'b0}}};

    typedef logic        [CHAN_W-1:0]   t_chan;
    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic        [STAMP_W-1:0]  t_stamp;
    typedef logic        [MAG_W-1:0]    t_mag;

    typedef enum logic [3:0] {
        S_IDLE,
        S_READ,
        S_PREP,
        S_DIV,
        S_WB,
        S_MUL,
        S_ROUND,
        S_SUM,
        S_OUT
    } t_state;

endpackage

// ===== hw/rtl/ple_in_if.sv =====
interface ple_in_if;
    import ple_pkg::*;

    logic    valid;
    logic    ready;
    logic    req_type;
    t_chan   channel;
    t_sample sample_value;
    t_stamp  time_ns;

    modport source (output valid, req_type, channel, sample_value, time_ns, input ready);
    modport sink   (input valid, req_type, channel, sample_value, time_ns, output ready);
endinterface

// ===== hw/rtl/ple_out_if.sv =====
interface ple_out_if;
    import ple_pkg::*;

    logic    valid;
    logic    ready;
    t_chan   out_channel;
    t_sample out_value;

    modport source (output valid, out_channel, out_value, input ready);
    modport sink   (input valid, out_channel, out_value, output ready);
endinterface

// ===== hw/rtl/per_channel_linear_extrapolator.sv =====
// Channel  Direction  Transaction
// i_req    in         req_type, channel, sample_value, time_ns
// o_res    out        out_channel, out_value (queries with a valid slope only)
//
// One transaction at a time; i_req.ready is high only while no transaction is in work.
// An update runs 48 restoring divide steps before write-back when it derives a slope.
// A query runs 48 shift-add multiply steps, then rounds and sums, then waits on
// o_res.ready; the divide and multiply share one 49-bit add/subtract unit.
// Reset clears the seen and slope-valid flags at once; no clearing pass is needed.
module per_channel_linear_extrapolator #(
    parameter int NUM_CHANNELS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ple_in_if.sink    i_req,
    ple_out_if.source o_res
);
    import ple_pkg::*;

    localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    t_state r_state, n_state;

    logic    r_req_type;
    t_chan   r_channel;
    t_sample r_sample;
    t_stamp  r_time;

    logic [NUM_CHANNELS-1:0] r_seen;
    logic [NUM_CHANNELS-1:0] r_slope_ok;

    t_sample mem_sample [NUM_CHANNELS];
    t_stamp  mem_stamp  [NUM_CHANNELS];
    logic    mem_sneg   [NUM_CHANNELS];
    t_mag    mem_smag   [NUM_CHANNELS];

    t_sample r_last;
    t_stamp  r_stamp;
    logic    r_sneg;
    t_mag    r_smag;

    logic [MAG_W:0]   r_acc;
    t_mag             r_q;
    t_mag             r_opb;
    logic             r_dneg;
    logic             r_wr_slope;
    logic [CNT_W-1:0] r_cnt;
    logic [CAP_W-1:0] r_mag;
    t_chan            r_out_channel;
    t_sample          r_out_value;

    logic [IDX_W-1:0] idx;
    logic             chan_ok;
    logic             cnt_last;
    t_stamp           dt;
    logic             dt_zero;
    logic signed [SAMPLE_W:0] diff;
    logic [SAMPLE_W:0] diff_abs;

    logic [MAG_W:0]   sh_a;
    logic [MAG_W:0]   sh_b;
    logic             sh_sub;
    logic [MAG_W+1:0] sh_sum;

    logic [PROD_W-1:0]        rnd_sum;
    logic [PROD_W-17:0]       rnd_m;
    logic signed [CAP_W:0]    sum_r;

    assign idx      = IDX_W'(r_channel);
    assign chan_ok  = 32'(r_channel) < 32'(NUM_CHANNELS);
    assign cnt_last = (r_cnt == CNT_W'(STEPS - 1));
    assign dt       = r_time - r_stamp;
    assign dt_zero  = (dt == '0);
    assign diff     = (SAMPLE_W+1)'(r_sample) - (SAMPLE_W+1)'(r_last);
    assign diff_abs = diff[SAMPLE_W] ? (SAMPLE_W+1)'(-diff) : diff;

    assign sh_sum = {1'b0, sh_a} + {1'b0, (sh_sub ? ~sh_b : sh_b)} + (MAG_W+2)'(sh_sub);

    assign rnd_sum = {r_acc[MAG_W-1:0], r_q} + (r_sneg ? PROD_W'(16'hFFFF) : '0);
    assign rnd_m   = rnd_sum[PROD_W-1:16];
    assign sum_r   = r_sneg ? ((CAP_W+1)'(r_last) - (CAP_W+1)'(r_mag))
                            : ((CAP_W+1)'(r_last) + (CAP_W+1)'(r_mag));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_req.valid) n_state = S_READ;
            S_READ:  n_state = chan_ok ? S_PREP : S_IDLE;
            S_PREP: begin
                if (r_req_type == REQ_UPDATE) begin
                    n_state = (r_seen[idx] && !dt_zero) ? S_DIV : S_WB;
                end else begin
                    n_state = r_slope_ok[idx] ? S_MUL : S_IDLE;
                end
            end
            S_DIV:   if (cnt_last) n_state = S_WB;
            S_WB:    n_state = S_IDLE;
            S_MUL:   if (cnt_last) n_state = S_ROUND;
            S_ROUND: n_state = S_SUM;
            S_SUM:   n_state = S_OUT;
            S_OUT:   if (o_res.ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        i_req.ready       = (r_state == S_IDLE);
        o_res.valid       = (r_state == S_OUT);
        o_res.out_channel = r_out_channel;
        o_res.out_value   = r_out_value;
        sh_sub            = 1'b0;
        sh_a              = {1'b0, r_acc[MAG_W-1:0]};
        sh_b              = r_q[0] ? {1'b0, r_opb} : '0;
        if (r_state == S_DIV) begin
            sh_sub = 1'b1;
            sh_a   = {r_acc[MAG_W-1:0], r_q[MAG_W-1]};
            sh_b   = {1'b0, r_opb};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_seen     <= '0;
            r_slope_ok <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_WB) begin
                r_seen[idx] <= 1'b1;
                if (r_wr_slope) r_slope_ok[idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_READ && chan_ok) begin
            r_last  <= mem_sample[idx];
            r_stamp <= mem_stamp[idx];
            r_sneg  <= mem_sneg[idx];
            r_smag  <= mem_smag[idx];
        end
        if (r_state == S_WB) begin
            mem_sample[idx] <= r_sample;
            mem_stamp[idx]  <= r_time;
            if (r_wr_slope) begin
                mem_sneg[idx] <= r_dneg && (r_q != '0);
                mem_smag[idx] <= r_q;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    r_req_type <= i_req.req_type;
                    r_channel  <= i_req.channel;
                    r_sample   <= i_req.sample_value;
                    r_time     <= i_req.time_ns;
                end
            end
            S_PREP: begin
                r_cnt      <= '0;
                r_acc      <= '0;
                r_wr_slope <= (r_req_type == REQ_UPDATE) && r_seen[idx] && !dt_zero;
                if (r_req_type == REQ_UPDATE) begin
                    r_dneg     <= diff[SAMPLE_W];
                    r_q        <= {diff_abs[SAMPLE_W-1:0], 16'h0000};
                    r_opb      <= dt;
                end else begin
                    r_q   <= dt;
                    r_opb <= r_smag;
                end
            end
            S_DIV: begin
                r_cnt <= r_cnt + 1'b1;
                if (sh_sum[MAG_W+1]) begin
                    r_acc <= sh_sum[MAG_W:0];
                end else begin
                    r_acc <= {r_acc[MAG_W-1:0], r_q[MAG_W-1]};
                end
                r_q <= {r_q[MAG_W-2:0], sh_sum[MAG_W+1]};
            end
            S_MUL: begin
                r_cnt <= r_cnt + 1'b1;
                r_acc <= {1'b0, sh_sum[MAG_W:1]};
                r_q   <= {sh_sum[0], r_q[MAG_W-1:1]};
            end
            S_ROUND: begin
                r_mag <= (rnd_m > (PROD_W-16)'(MAG_CAP)) ? MAG_CAP : rnd_m[CAP_W-1:0];
            end
            S_SUM: begin
                r_out_channel <= r_channel;
                if (sum_r[CAP_W:SAMPLE_W-1] == '0 || sum_r[CAP_W:SAMPLE_W-1] == '1) begin
                    r_out_value <= sum_r[SAMPLE_W-1:0];
                end else if (sum_r[CAP_W]) begin
                    r_out_value <= {1'b1, {(SAMPLE_W-1){1'b0}}};
                end else begin
                    r_out_value <= {1'b0, {(SAMPLE_W-1){1'b1}}};
                end
            end
            default: begin
            end
        endcase
    end

endmodule
